// File: rtl/rrds_pkg.sv
package rrds_pkg;

	localparam int TASK_SLOTS_DEF = 8;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_DELAY  = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAKE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start_tick;
		logic start_delay;
		logic start_switch;
		logic start_other;
		logic wake_step;
		logic search_step;
	} ctrl_t;

	typedef struct packed {
		logic wake_last;
		logic found;
		logic search_last;
	} status_t;

endpackage

// File: rtl/rrds_ctrl.sv
module rrds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       cmd,
	input  rrds_pkg::status_t stat,
	output rrds_pkg::ctrl_t  ctrl,
	output logic             busy,
	output logic             done
);

	rrds_pkg::state_t state_q;
	rrds_pkg::state_t state_d;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy   = (state_q == rrds_pkg::ST_WAKE) || (state_q == rrds_pkg::ST_SEARCH);
	assign done   = (state_q == rrds_pkg::ST_DONE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			rrds_pkg::ST_IDLE, rrds_pkg::ST_DONE: begin
				if (accept) begin
					case (cmd)
						rrds_pkg::CMD_TICK: begin
							ctrl.start_tick = 1'b1;
							state_d         = rrds_pkg::ST_WAKE;
						end
						rrds_pkg::CMD_DELAY: begin
							ctrl.start_delay = 1'b1;
							state_d          = rrds_pkg::ST_DONE;
						end
						rrds_pkg::CMD_SWITCH: begin
							ctrl.start_switch = 1'b1;
							state_d           = rrds_pkg::ST_SEARCH;
						end
						default: begin
							ctrl.start_other = 1'b1;
							state_d          = rrds_pkg::ST_DONE;
						end
					endcase
				end else begin
					state_d = rrds_pkg::ST_IDLE;
				end
			end
			rrds_pkg::ST_WAKE: begin
				ctrl.wake_step = 1'b1;
				if (stat.wake_last) begin
					state_d = rrds_pkg::ST_DONE;
				end
			end
			rrds_pkg::ST_SEARCH: begin
				ctrl.search_step = 1'b1;
				if (stat.found || stat.search_last) begin
					state_d = rrds_pkg::ST_DONE;
				end
			end
			default: begin
				state_d = rrds_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/rrds_datapath.sv
module rrds_datapath #(
	parameter int TASK_SLOTS = rrds_pkg::TASK_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rrds_pkg::ctrl_t   ctrl,
	input  logic [31:0]       delay_ticks,
	output rrds_pkg::status_t stat,
	output logic              switch_request,
	output logic [2:0]        running_task,
	output logic [7:0]        ready_mask
);

	localparam int SW = $clog2(TASK_SLOTS);
	localparam int RW = (TASK_SLOTS > 8) ? TASK_SLOTS : 8;
	localparam int CW = (SW > 3) ? SW : 3;
	localparam logic [SW-1:0] LAST_IDX  = SW'(TASK_SLOTS - 1);
	localparam logic [SW-1:0] LAST_SRCH = SW'(TASK_SLOTS - 2);
	localparam logic [SW:0]   SLOTS_W   = (SW+1)'(TASK_SLOTS);

	logic [31:0]           tick_q;
	logic [31:0]           wake_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] ready_q;
	logic [SW-1:0]         cur_q;
	logic [SW-1:0]         idx_q;
	logic [SW-1:0]         probe_q;
	logic                  req_q;

	logic [SW:0]   probe_inc;
	logic [SW-1:0] probe_nxt;
	logic [RW-1:0] ready_pad;
	logic [CW-1:0] cur_pad;

	always_comb begin
		probe_inc = {1'b0, probe_q} + (SW+1)'(1);
		if (probe_inc >= SLOTS_W) begin
			probe_nxt = SW'(1);
		end else begin
			probe_nxt = probe_inc[SW-1:0];
		end
	end

	assign stat.wake_last   = (idx_q == LAST_IDX);
	assign stat.found       = ready_q[probe_nxt];
	assign stat.search_last = (idx_q == LAST_SRCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			ready_q <= '1;
			cur_q   <= SW'(1);
			idx_q   <= '0;
			probe_q <= '0;
			req_q   <= 1'b0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				wake_q[i] <= '0;
			end
		end else begin
			if (ctrl.start_tick) begin
				tick_q <= tick_q + 32'd1;
				idx_q  <= '0;
				req_q  <= 1'b1;
			end
			if (ctrl.start_delay) begin
				if (cur_q != '0) begin
					wake_q[cur_q]  <= tick_q + delay_ticks;
					ready_q[cur_q] <= 1'b0;
					req_q          <= 1'b1;
				end else begin
					req_q <= 1'b0;
				end
			end
			if (ctrl.start_switch) begin
				probe_q <= cur_q;
				idx_q   <= '0;
				req_q   <= 1'b0;
			end
			if (ctrl.start_other) begin
				req_q <= 1'b0;
			end
			if (ctrl.wake_step) begin
				if (wake_q[idx_q] <= tick_q) begin
					ready_q[idx_q] <= 1'b1;
				end
				idx_q <= idx_q + SW'(1);
			end
			if (ctrl.search_step) begin
				if (stat.found) begin
					cur_q <= probe_nxt;
				end else if (stat.search_last) begin
					cur_q <= '0;
				end
				probe_q <= probe_nxt;
				idx_q   <= idx_q + SW'(1);
			end
		end
	end

	assign ready_pad      = RW'(ready_q);
	assign cur_pad        = CW'(cur_q);
	assign ready_mask     = ready_pad[7:0];
	assign running_task   = cur_pad[2:0];
	assign switch_request = req_q;

endmodule

// File: rtl/round_robin_delay_scheduler_unit.sv
// channel  | signals                                  | handshake
// ---------+------------------------------------------+------------------------------
// event    | cmd[1:0], delay_ticks[31:0]              | taken when start && !busy
// result   | switch_request, running_task[2:0],       | one cycle, marked by done
//          | ready_mask[7:0]                          |
//
// delay, unused cmd: done in the cycle right after the transaction is taken
// tick: done after TASK_SLOTS wake cycles, one wake compare per slot per cycle
// switch: done after at most TASK_SLOTS-1 probe cycles, one round-robin probe per cycle
// a new transaction may be taken in the cycle its predecessor's result shows
// arst_n resets all slots ready, wake times and tick count zero, slot 1 running
// results cannot be stalled, done is a single-cycle strobe
module round_robin_delay_scheduler_unit #(
	parameter int TASK_SLOTS = rrds_pkg::TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] delay_ticks,
	output logic        done,
	output logic        switch_request,
	output logic [2:0]  running_task,
	output logic [7:0]  ready_mask
);

	rrds_pkg::ctrl_t   ctrl;
	rrds_pkg::status_t stat;

	rrds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	rrds_datapath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.delay_ticks    (delay_ticks),
		.stat           (stat),
		.switch_request (switch_request),
		.running_task   (running_task),
		.ready_mask     (ready_mask)
	);

endmodule

// File: tb/round_robin_delay_scheduler_unit_test.sv
`timescale 1ns / 1ps

module round_robin_delay_scheduler_unit_test;

	localparam int SLOTS = rrds_pkg::TASK_SLOTS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = SLOTS + 6;

	typedef struct packed {
		logic       req;
		logic [2:0] running;
		logic [7:0] mask;
	} outcome_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = rrds_pkg::CMD_TICK;
	logic [31:0] delay_ticks = '0;
	logic        busy;
	logic        done;
	logic        switch_request;
	logic [2:0]  running_task;
	logic [7:0]  ready_mask;

	logic [SLOTS-1:0] sched_ready;
	logic [31:0]      sched_wake [SLOTS];
	logic [31:0]      sched_ticks;
	int               sched_slot;

	outcome_t pending_outcomes [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       sender_idle_pct = 0;

	round_robin_delay_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.delay_ticks(delay_ticks),
		.done(done),
		.switch_request(switch_request),
		.running_task(running_task),
		.ready_mask(ready_mask)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic outcome_t advance_scheduler(logic [1:0] c, logic [31:0] d);
		outcome_t o;
		int probe;
		int chosen;
		logic hit;
		o.req = 1'b0;
		case (c)
			rrds_pkg::CMD_TICK: begin
				sched_ticks = sched_ticks + 32'd1;
				for (int i = 0; i < SLOTS; i++)
					if (sched_wake[i] <= sched_ticks)
						sched_ready[i] = 1'b1;
				o.req = 1'b1;
			end
			rrds_pkg::CMD_DELAY: begin
				if (sched_slot != 0) begin
					sched_wake[sched_slot] = sched_ticks + d;
					sched_ready[sched_slot] = 1'b0;
					o.req = 1'b1;
				end
			end
			rrds_pkg::CMD_SWITCH: begin
				probe = sched_slot;
				chosen = 0;
				hit = 1'b0;
				for (int n = 0; n < SLOTS; n++) begin
					if (!hit) begin
						probe++;
						if (probe >= SLOTS)
							probe = 1;
						if (sched_ready[probe]) begin
							chosen = probe;
							hit = 1'b1;
						end
					end
				end
				sched_slot = chosen;
			end
			default: ;
		endcase
		o.running = 3'(sched_slot);
		o.mask = 8'(sched_ready);
		return o;
	endfunction

	// random idle cycles with start low, then one transaction
	task automatic send_event(input logic [1:0] c, input logic [31:0] d);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		delay_ticks <= d;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_outcomes.push_back(advance_scheduler(c, d));
	endtask

	task automatic send_random_event();
		int pick;
		logic [1:0] c;
		logic [31:0] d;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			c = rrds_pkg::CMD_TICK;
		else if (pick < 65)
			c = rrds_pkg::CMD_DELAY;
		else if (pick < 95)
			c = rrds_pkg::CMD_SWITCH;
		else
			c = CMD_UNUSED;
		pick = $urandom_range(0, 99);
		// delays near the top of the range make the wake time wrap around the tick count
		if (pick < 70)
			d = $urandom_range(0, 15);
		else if (pick < 96)
			d = 32'hFFFF_FFFF - $urandom_range(0, 7);
		else
			d = $urandom();
		send_event(c, d);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no transaction pending");
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (switch_request !== want.req) begin
					$error("switch_request expected %0d got %0d", want.req, switch_request);
					fail_count++;
				end
				if (running_task !== want.running) begin
					$error("running_task expected %0d got %0d", want.running, running_task);
					fail_count++;
				end
				if (ready_mask !== want.mask) begin
					$error("ready_mask expected %h got %h", want.mask, ready_mask);
					fail_count++;
				end
			end
		end
	end

	task automatic test_unused_command();
		send_event(CMD_UNUSED, 32'hFFFF_FFFF);
		send_event(CMD_UNUSED, 32'h0000_0000);
	endtask

	task automatic test_zero_delay();
		send_event(rrds_pkg::CMD_DELAY, 32'd0);
		send_event(rrds_pkg::CMD_TICK, 32'd0);
	endtask

	// wake time wraps to one below the counter
	task automatic test_wrapping_delay();
		send_event(rrds_pkg::CMD_DELAY, 32'hFFFF_FFFF);
		send_event(rrds_pkg::CMD_TICK, 32'hFFFF_FFFF);
	endtask

	task automatic test_round_robin();
		repeat (3) send_event(rrds_pkg::CMD_SWITCH, 32'hAAAA_5555);
	endtask

	// block every task, fall back to idle, delay from idle does nothing
	task automatic test_idle_fallback();
		for (int i = 1; i < SLOTS; i++) begin
			send_event(rrds_pkg::CMD_DELAY, 32'd6 + 32'(i));
			send_event(rrds_pkg::CMD_SWITCH, 32'd0);
		end
		send_event(rrds_pkg::CMD_DELAY, 32'd5);
		send_event(rrds_pkg::CMD_TICK, 32'd0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		sender_idle_pct = idle_pct;
		repeat (count) send_random_event();
	endtask

	initial begin
		sched_ready = '1;
		for (int i = 0; i < SLOTS; i++)
			sched_wake[i] = '0;
		sched_ticks = '0;
		sched_slot = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 32;
		test_unused_command();
		test_zero_delay();
		test_wrapping_delay();
		test_round_robin();
		test_idle_fallback();
		test_random_traffic(32, 170);
		test_random_traffic(67, 170);
		test_random_traffic(0, 170);
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
